[rtl/core/hsa_pkg.sv]
// ----------------------------------------------------------------------------
// hsa_pkg: shared types for the heap sort array block
// Data width and the signed value type carried on both stream channels.
// ----------------------------------------------------------------------------
`default_nettype none

package hsa_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

[rtl/core/heap_sort_array_top.sv]
// ----------------------------------------------------------------------------
// heap_sort_array_top: collect-then-sort block for signed 32-bit values
// Stores incoming values, heap-sorts them in place and streams them out
// in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on the s_axis channel carry one signed value each in tdata.
//   Values are written to an internal store, one beat per cycle, until a beat
//   with tlast high arrives or the beat that fills the store (MAX_ITEMS
//   values) arrives. That beat closes the set.
//   The set is then sorted by an in-place max-heap sort. A small sequencer
//   drives one memory read port, one write port and a single signed
//   comparator. Each sift level steps through a child check, a left-child
//   read, a right-child read when that child exists and a compare; the
//   store's single read port sets that order.
//   The sorted values leave on the m_axis channel in ascending order; each
//   beat is read from the store and then loaded, and tlast marks the
//   greatest value of the set. A set of one value goes straight to output.
//   s_axis_tready_o is high only while the block collects values; during the
//   sort and the output phase it is low.
//   The output is a register stage: when the receiver stalls, the held beat
//   stays and the sequencer waits. Once the last beat of a set is loaded the
//   block collects the next set, even while that beat still waits.
//   Reset empties the store and clears the output; the store contents need no
//   clearing since only values of the current set are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_array_top #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // Input beats. tdata: sample_value [31:0].
  input  wire logic           s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire hsa_pkg::data_t s_axis_tdata_i,
  input  wire logic           s_axis_tlast_i,   // is_final
  // Result beats. tdata: sorted_value [31:0].
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output hsa_pkg::data_t      m_axis_tdata_o,
  output logic                m_axis_tlast_o    // end_of_run
);
  import hsa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIFT_TOP,
    ST_SIFT_CUR,
    ST_SIFT_CHK,
    ST_SIFT_L,
    ST_SIFT_R,
    ST_SIFT_CMP,
    ST_SIFT_PUT,
    ST_EXT_RD0,
    ST_EXT_RDI,
    ST_EXT_SWP,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q;
  logic [AW-1:0]   nlast_q;   // index of the greatest entry of the set
  logic [AW-1:0]   last_q;    // last heap index of the current sift
  logic [AW-1:0]   node_q;    // hole being sifted
  logic [AW-1:0]   i_q;       // build / extraction counter
  logic [AW-1:0]   k_q;       // output index
  logic [AW-1:0]   big_q;     // chosen child
  logic            ext_q;     // 0 while building the heap, 1 while extracting
  data_t           cur_q;     // value being sifted down
  data_t           bigv_q;    // value of the chosen child, or the extracted max
  logic            m_valid_q;
  data_t           m_data_q;
  logic            m_last_q;

  // Store with one write port and one registered read port.
  data_t           mem [MAX_ITEMS];
  data_t           rdata_q;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [AW-1:0]   wa;
  data_t           wd;

  logic            s_fire;
  logic            close_set;
  logic [CW-1:0]   n_half;
  logic [AW:0]     lc;
  logic [AW:0]     rc;
  logic            has_right;
  logic            out_free;
  logic            emit_load;
  data_t           cmp_a;
  data_t           cmp_b;
  logic            a_lt_b;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign close_set       = s_axis_tlast_i || (cnt_q == CW'(MAX_ITEMS - 1));
  assign n_half          = (cnt_q + CW'(1)) >> 1;

  // Node 0 has node 1 as its only child; node k has children 2k and 2k+1.
  assign lc        = (node_q == '0) ? (AW+1)'(1) : {node_q, 1'b0};
  assign rc        = lc + (AW+1)'(1);
  assign has_right = (node_q != '0) && (rc <= {1'b0, last_q});
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign emit_load = (state_q == ST_EMIT_LD) && out_free;

  // The one shared comparator: right child against left, or sifted value
  // against the larger child.
  always_comb begin
    if (state_q == ST_SIFT_R) begin
      cmp_a = rdata_q;
    end else begin
      cmp_a = cur_q;
    end
    cmp_b  = bigv_q;
    a_lt_b = cmp_a < cmp_b;
  end

  always_comb begin
    case (state_q)
      ST_SIFT_TOP: rd_addr = node_q;
      ST_SIFT_CHK: rd_addr = lc[AW-1:0];
      ST_SIFT_L:   rd_addr = rc[AW-1:0];
      ST_EXT_RD0:  rd_addr = '0;
      ST_EXT_RDI:  rd_addr = i_q;
      ST_EMIT_RD:  rd_addr = k_q;
      ST_EMIT_LD:  rd_addr = k_q;
      default:     rd_addr = '0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = node_q;
    wd = cur_q;
    case (state_q)
      ST_IDLE: begin
        we = s_fire;
        wa = cnt_q[AW-1:0];
        wd = s_axis_tdata_i;
      end
      ST_SIFT_CMP: begin
        we = a_lt_b;
        wd = bigv_q;
      end
      ST_SIFT_PUT: begin
        we = 1'b1;
      end
      ST_EXT_SWP: begin
        we = 1'b1;
        wa = i_q;
        wd = bigv_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      nlast_q   <= '0;
      last_q    <= '0;
      node_q    <= '0;
      i_q       <= '0;
      k_q       <= '0;
      big_q     <= '0;
      ext_q     <= 1'b0;
      cur_q     <= '0;
      bigv_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i && !emit_load) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            if (close_set) begin
              cnt_q   <= '0;
              nlast_q <= cnt_q[AW-1:0];
              last_q  <= cnt_q[AW-1:0];
              ext_q   <= 1'b0;
              k_q     <= '0;
              i_q     <= AW'(n_half);
              node_q  <= AW'(n_half);
              if (cnt_q == '0) begin
                state_q <= ST_EMIT_RD;
              end else begin
                state_q <= ST_SIFT_TOP;
              end
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        ST_SIFT_TOP: begin
          state_q <= ST_SIFT_CUR;
        end
        ST_SIFT_CUR: begin
          cur_q   <= rdata_q;
          state_q <= ST_SIFT_CHK;
        end
        ST_SIFT_CHK: begin
          if (lc > {1'b0, last_q}) begin
            state_q <= ST_SIFT_PUT;
          end else begin
            state_q <= ST_SIFT_L;
          end
        end
        ST_SIFT_L: begin
          big_q  <= lc[AW-1:0];
          bigv_q <= rdata_q;
          if (has_right) begin
            state_q <= ST_SIFT_R;
          end else begin
            state_q <= ST_SIFT_CMP;
          end
        end
        ST_SIFT_R: begin
          // Ties go to the right child.
          if (!a_lt_b) begin
            big_q  <= rc[AW-1:0];
            bigv_q <= rdata_q;
          end
          state_q <= ST_SIFT_CMP;
        end
        ST_SIFT_CMP: begin
          if (a_lt_b) begin
            node_q  <= big_q;
            state_q <= ST_SIFT_CHK;
          end else begin
            state_q <= ST_SIFT_PUT;
          end
        end
        ST_SIFT_PUT: begin
          if (!ext_q) begin
            if (i_q == '0) begin
              ext_q   <= 1'b1;
              i_q     <= nlast_q;
              state_q <= ST_EXT_RD0;
            end else begin
              i_q     <= i_q - AW'(1);
              node_q  <= i_q - AW'(1);
              state_q <= ST_SIFT_TOP;
            end
          end else begin
            if (i_q == AW'(1)) begin
              k_q     <= '0;
              state_q <= ST_EMIT_RD;
            end else begin
              i_q     <= i_q - AW'(1);
              state_q <= ST_EXT_RD0;
            end
          end
        end
        ST_EXT_RD0: begin
          state_q <= ST_EXT_RDI;
        end
        ST_EXT_RDI: begin
          bigv_q  <= rdata_q;
          state_q <= ST_EXT_SWP;
        end
        ST_EXT_SWP: begin
          // The heap top moves to the end; the end value sifts from the root.
          cur_q   <= rdata_q;
          node_q  <= '0;
          last_q  <= i_q - AW'(1);
          state_q <= ST_SIFT_CHK;
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= rdata_q;
            m_last_q  <= (k_q == nlast_q);
            if (k_q == nlast_q) begin
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + AW'(1);
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // A closing beat always starts a sort or an output phase.
  a_close_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && close_set) |=> !s_axis_tready_o)
    else $error("collection continued after a closing beat");

  // The chosen child lies below the hole and inside the heap.
  a_child_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIFT_CMP) |-> ((big_q <= last_q) && (big_q != node_q)))
    else $error("sift chose a child outside the heap");

  // Extraction never swaps the root with itself.
  a_ext_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXT_SWP) |-> (i_q != '0))
    else $error("extraction index reached the root");

  // A result beat is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i && (state_q == ST_EMIT_LD)) |=>
      (state_q == ST_EMIT_LD))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
